// File: sv/tbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbp_pkg
// shared constants and the 2-bit saturating counter step for the predictor
// ----------------------------------------------------------------------------
package tbp_pkg;

  localparam int BIMODAL_ENTRIES = 4096;
  localparam int HISTORY_ENTRIES = 512;
  localparam int HISTORY_BITS    = 6;
  localparam int PATTERN_ROWS    = 8;
  localparam int CHOOSER_ENTRIES = 4096;

  localparam logic [1:0] CTR_MAX = 2'd3;
  localparam logic [1:0] CTR_MIN = 2'd0;

  // reset contents of the counter stores
  localparam logic [1:0] BIMODAL_INIT = 2'd0;
  localparam logic [1:0] PATTERN_INIT = 2'd1;
  localparam logic [1:0] CHOOSER_INIT = 2'd1;

  function automatic logic [1:0] sat_step(input logic [1:0] ctr, input logic up);
    logic [1:0] res;
    res = ctr;
    if (up) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: sv/tbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbp_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: sv/tournament_branch_predictor.sv
// accepted requests step through ST_HIST and ST_PAT (the pattern address
//   needs the history read data); a result beat is registered once the
//   output register is free; no new request is taken until ST_IDLE.
// reset: synchronous active-low; then, with in_ready low, a clearing pass
//   over the deepest table (4096 entries by default) writes reset values
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// hybrid bimodal / two-level local predictor with a 2-bit chooser table
// ----------------------------------------------------------------------------
module tournament_branch_predictor #(
  parameter int BIMODAL_ENTRIES = tbp_pkg::BIMODAL_ENTRIES,
  parameter int HISTORY_ENTRIES = tbp_pkg::HISTORY_ENTRIES,
  parameter int HISTORY_BITS    = tbp_pkg::HISTORY_BITS,
  parameter int PATTERN_ROWS    = tbp_pkg::PATTERN_ROWS,
  parameter int CHOOSER_ENTRIES = tbp_pkg::CHOOSER_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_branch_pc,
  input  wire logic        in_taken,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_prediction,
  output logic             out_counter_guess,
  output logic             out_history_guess
);

  // table geometry
  localparam int PAT_DEPTH = PATTERN_ROWS << HISTORY_BITS;
  localparam int BIM_AW    = $clog2(BIMODAL_ENTRIES);
  localparam int HIST_AW   = $clog2(HISTORY_ENTRIES);
  localparam int PAT_AW    = $clog2(PAT_DEPTH);
  localparam int CHO_AW    = $clog2(CHOOSER_ENTRIES);
  localparam int ROW_BITS  = $clog2(PATTERN_ROWS);

  // clearing pass covers the deepest table
  localparam int MAX_A     = (BIMODAL_ENTRIES > CHOOSER_ENTRIES) ?
                             BIMODAL_ENTRIES : CHOOSER_ENTRIES;
  localparam int MAX_B     = (HISTORY_ENTRIES > PAT_DEPTH) ? HISTORY_ENTRIES : PAT_DEPTH;
  localparam int CLR_DEPTH = (MAX_A > MAX_B) ? MAX_A : MAX_B;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_HIST  = 4'b0100,   // first-level reads back, issue pattern read
    ST_PAT   = 4'b1000    // pattern read back, train and present result
  } state_t;

  state_t             state_r, state_nxt;
  logic [CLR_W-1:0]   clr_idx_r, clr_idx_nxt;

  // captured request beat
  logic               mode_r;
  logic [31:0]        pc_r;
  logic               taken_r;

  // guesses of the most recent predict beat, used to train the chooser
  logic               last_cg_r, last_cg_nxt;
  logic               last_hg_r, last_hg_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic               out_pred_r, out_cg_r, out_hg_r;

  logic               accept;
  logic               out_free;
  logic               finish;
  logic               clearing;

  // ram ports
  logic [1:0]              bim_rdata, bim_wdata;
  logic [BIM_AW-1:0]       bim_waddr;
  logic                    bim_we;
  logic [HISTORY_BITS-1:0] hist_rdata, hist_wdata;
  logic [HIST_AW-1:0]      hist_waddr;
  logic                    hist_we;
  logic [1:0]              pat_rdata, pat_wdata;
  logic [PAT_AW-1:0]       pat_addr, pat_waddr;
  logic                    pat_we;
  logic [1:0]              cho_rdata, cho_wdata;
  logic [CHO_AW-1:0]       cho_waddr;
  logic                    cho_we;

  // component guesses and chooser training
  logic               cg, hg, pick;
  logic               cok, hok;
  logic               train;

  assign clearing = (state_r == ST_CLEAR);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  // training and result load happen once, when the output register is free
  assign finish   = (state_r == ST_PAT) && out_free;
  assign train    = finish && mode_r;

  // row = pc mod rows in the upper bits, local history in the lower bits
  assign pat_addr = PAT_AW'((PAT_AW'(pc_r) & PAT_AW'(PATTERN_ROWS - 1)) << HISTORY_BITS)
                  | PAT_AW'(hist_rdata);

  assign cg   = bim_rdata[1];
  assign hg   = pat_rdata[1];
  assign pick = cho_rdata[1] ? hg : cg;
  assign cok  = (last_cg_r == taken_r);
  assign hok  = (last_hg_r == taken_r);

  // ---- write ports: clearing pass or training write-back ----
  always_comb begin
    if (clearing) begin
      bim_we     = 1'b1;
      bim_waddr  = BIM_AW'(clr_idx_r);
      bim_wdata  = tbp_pkg::BIMODAL_INIT;
      hist_we    = 1'b1;
      hist_waddr = HIST_AW'(clr_idx_r);
      hist_wdata = '0;
      pat_we     = 1'b1;
      pat_waddr  = PAT_AW'(clr_idx_r);
      pat_wdata  = tbp_pkg::PATTERN_INIT;
      cho_we     = 1'b1;
      cho_waddr  = CHO_AW'(clr_idx_r);
      cho_wdata  = tbp_pkg::CHOOSER_INIT;
    end else begin
      bim_we     = train;
      bim_waddr  = BIM_AW'(pc_r);
      bim_wdata  = tbp_pkg::sat_step(bim_rdata, taken_r);
      hist_we    = train;
      hist_waddr = HIST_AW'(pc_r >> ROW_BITS);
      // shift in the outcome, oldest bit drops off
      hist_wdata = HISTORY_BITS'({hist_rdata, taken_r});
      pat_we     = train;
      pat_waddr  = pat_addr;
      pat_wdata  = tbp_pkg::sat_step(pat_rdata, taken_r);
      // chooser moves only when exactly one component was right
      cho_we     = train && (hok != cok);
      cho_waddr  = CHO_AW'(pc_r >> 2);
      cho_wdata  = tbp_pkg::sat_step(cho_rdata, hok);
    end
  end

  // ---- tables ----
  tbp_ram #(.WIDTH(2), .DEPTH(BIMODAL_ENTRIES)) u_bim_ram (
    .clk   (clk),
    .we    (bim_we),
    .waddr (bim_waddr),
    .wdata (bim_wdata),
    .re    (accept),
    .raddr (BIM_AW'(in_branch_pc)),
    .rdata (bim_rdata)
  );

  tbp_ram #(.WIDTH(HISTORY_BITS), .DEPTH(HISTORY_ENTRIES)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (accept),
    .raddr (HIST_AW'(in_branch_pc >> ROW_BITS)),
    .rdata (hist_rdata)
  );

  // second-level read is issued in the cycle after the history read
  tbp_ram #(.WIDTH(2), .DEPTH(PAT_DEPTH)) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .re    (state_r == ST_HIST),
    .raddr (pat_addr),
    .rdata (pat_rdata)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(CHOOSER_ENTRIES)) u_cho_ram (
    .clk   (clk),
    .we    (cho_we),
    .waddr (cho_waddr),
    .wdata (cho_wdata),
    .re    (accept),
    .raddr (CHO_AW'(in_branch_pc >> 2)),
    .rdata (cho_rdata)
  );

  // ---- sequencer ----
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    last_cg_nxt   = last_cg_r;
    last_hg_nxt   = last_hg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + CLR_W'(1);
        if (clr_idx_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) state_nxt = ST_HIST;
      end
      ST_HIST: begin
        state_nxt = ST_PAT;
      end
      ST_PAT: begin
        // wait here while the previous result beat is still pending
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (!mode_r) begin
            last_cg_nxt = cg;
            last_hg_nxt = hg;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      last_cg_r   <= 1'b1;
      last_hg_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      last_cg_r   <= last_cg_nxt;
      last_hg_r   <= last_hg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      pc_r    <= in_branch_pc;
      taken_r <= in_taken;
    end
    if (finish) begin
      // update beats report the latched guesses and no prediction
      out_pred_r <= mode_r ? 1'b0 : pick;
      out_cg_r   <= mode_r ? last_cg_r : cg;
      out_hg_r   <= mode_r ? last_hg_r : hg;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_prediction    = out_pred_r;
  assign out_counter_guess = out_cg_r;
  assign out_history_guess = out_hg_r;

endmodule
`default_nettype wire
